FILE: src/sorted_unique_key_table_top_assert.svh
// ----------------------------------------------------------------------------
// sorted_unique_key_table_top_assert.svh
// assertion macros for the sorted key table
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_KEY_TABLE_TOP_ASSERT_SVH
`define SORTED_UNIQUE_KEY_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SUK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define SUK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/suk_pkg.sv
// ----------------------------------------------------------------------------
// suk_pkg
// types and constants shared by the sorted key table and its cells
// ----------------------------------------------------------------------------
package suk_pkg;

   localparam int KEY_W   = 34;
   localparam int PAY_W   = 32;
   localparam int CMD_W   = 2;
   localparam int FIELD_W = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } suk_req_type;

   typedef struct packed {
      logic               ok;
      logic [FIELD_W-1:0] position;
      logic [PAY_W-1:0]   found_payload;
      logic [FIELD_W-1:0] entry_count;
   } suk_rsp_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic capture;
      logic insert;
      logic remove;
   } suk_cell_ctl_type;

endpackage

FILE: src/suk_cell.sv
// ----------------------------------------------------------------------------
// suk_cell
// one slot of the sorted chain: holds a key and payload, compares against
// the broadcast key and shifts with its neighbors on insert or remove
// ----------------------------------------------------------------------------
module suk_cell (
   input  logic                        clock,
   input  suk_pkg::suk_cell_ctl_type   ctl,
   input  logic                        entry_valid,
   input  logic [suk_pkg::KEY_W-1:0]   key_in,
   input  logic [suk_pkg::PAY_W-1:0]   payload_in,
   input  logic                        left_lt,
   input  logic [suk_pkg::KEY_W-1:0]   left_key,
   input  logic [suk_pkg::PAY_W-1:0]   left_payload,
   input  logic [suk_pkg::KEY_W-1:0]   right_key,
   input  logic [suk_pkg::PAY_W-1:0]   right_payload,
   output logic [suk_pkg::KEY_W-1:0]   key_out,
   output logic [suk_pkg::PAY_W-1:0]   payload_out,
   output logic                        lt_out,
   output logic                        eq_out
);

   logic [suk_pkg::KEY_W-1:0] key_ff;
   logic [suk_pkg::PAY_W-1:0] payload_ff;
   logic                      lt_ff;
   logic                      eq_ff;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         lt_ff <= entry_valid && (key_ff < key_in);
         eq_ff <= entry_valid && (key_ff == key_in);
      end
      if (ctl.insert && !lt_ff) begin
         // first slot not below the key takes the new entry, the rest move up
         if (left_lt) begin
            key_ff     <= key_in;
            payload_ff <= payload_in;
         end else begin
            key_ff     <= left_key;
            payload_ff <= left_payload;
         end
      end else if (ctl.remove && !lt_ff) begin
         key_ff     <= right_key;
         payload_ff <= right_payload;
      end
   end

   assign key_out     = key_ff;
   assign payload_out = payload_ff;
   assign lt_out      = lt_ff;
   assign eq_out      = eq_ff;

endmodule

FILE: src/sorted_unique_key_table_top.sv
// ----------------------------------------------------------------------------
// sorted_unique_key_table_top
// sorted table of unique keys with payloads, built as a chain of cells
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_item (cmd, key, payload)
//  rsp      out        rsp_valid / rsp_ready  rsp_item (ok, position, ...)
//
//  every item passes through accept, then compare in all cells, then shift and respond
//  the compare and shift run in every cell at once, so the time per item does
//  not depend on CAPACITY
//  reset clears the entry count and the handshake state; stored keys stay
//  a stalled rsp holds the shift step until the result register frees up
// ----------------------------------------------------------------------------
`include "sorted_unique_key_table_top_assert.svh"

module sorted_unique_key_table_top #(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  suk_pkg::suk_req_type  req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output suk_pkg::suk_rsp_type  rsp_item
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CMP   = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   suk_pkg::suk_rsp_type    rsp_item_ff, rsp_item_in;
   suk_pkg::suk_req_type    item_ff;

   suk_pkg::suk_cell_ctl_type cell_ctl;

   logic [suk_pkg::KEY_W-1:0] key_arr     [CAPACITY];
   logic [suk_pkg::PAY_W-1:0] payload_arr [CAPACITY];
   logic [CAPACITY-1:0]       lt_vec;
   logic [CAPACITY-1:0]       eq_vec;
   logic [CAPACITY-1:0]       valid_vec;

   logic                      apply_go;
   logic                      found;
   logic                      full;
   logic                      insert_go;
   logic                      remove_go;
   logic [IW-1:0]             slot_idx;
   logic [suk_pkg::PAY_W-1:0] hit_payload;
   logic [CW-1:0]             slot_pos;

   // ---- cell chain ----
   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic                      l_lt;
         logic [suk_pkg::KEY_W-1:0] l_key;
         logic [suk_pkg::PAY_W-1:0] l_pay;
         logic [suk_pkg::KEY_W-1:0] r_key;
         logic [suk_pkg::PAY_W-1:0] r_pay;

         if (gi == 0) begin : g_first
            assign l_lt  = 1'b1;
            assign l_key = '0;
            assign l_pay = '0;
         end else begin : g_mid
            assign l_lt  = lt_vec[gi-1];
            assign l_key = key_arr[gi-1];
            assign l_pay = payload_arr[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_last
            assign r_key = '0;
            assign r_pay = '0;
         end else begin : g_inner
            assign r_key = key_arr[gi+1];
            assign r_pay = payload_arr[gi+1];
         end

         assign valid_vec[gi] = (count_ff > CW'(gi));

         suk_cell u_cell (
            .clock         (clock),
            .ctl           (cell_ctl),
            .entry_valid   (valid_vec[gi]),
            .key_in        (item_ff.key),
            .payload_in    (item_ff.payload),
            .left_lt       (l_lt),
            .left_key      (l_key),
            .left_payload  (l_pay),
            .right_key     (r_key),
            .right_payload (r_pay),
            .key_out       (key_arr[gi]),
            .payload_out   (payload_arr[gi]),
            .lt_out        (lt_vec[gi]),
            .eq_out        (eq_vec[gi])
         );
      end
   endgenerate

   // ---- boundary slot and hit payload ----
   always_comb begin
      slot_idx    = '0;
      hit_payload = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         // first slot whose key is not below the search key
         if (!lt_vec[j] && ((j == 0) || lt_vec[(j > 0) ? j - 1 : 0])) begin
            slot_idx = slot_idx | IW'(j);
         end
         if (eq_vec[j]) begin
            hit_payload = hit_payload | payload_arr[j];
         end
      end
   end

   assign slot_pos  = CW'(slot_idx) + CW'(1);
   assign found     = |eq_vec;
   assign full      = (count_ff == CW'(CAPACITY));
   assign apply_go  = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);
   assign insert_go = apply_go && (item_ff.cmd == suk_pkg::CMD_INSERT) && !found && !full;
   assign remove_go = apply_go && (item_ff.cmd == suk_pkg::CMD_REMOVE) && found;

   assign cell_ctl.capture = (state_ff == ST_CMP);
   assign cell_ctl.insert  = insert_go;
   assign cell_ctl.remove  = remove_go;

   // ---- sequencing and result ----
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (apply_go) begin
         rsp_valid_in              = 1'b1;
         rsp_item_in.ok            = 1'b0;
         rsp_item_in.position      = '0;
         rsp_item_in.found_payload = '0;
         case (item_ff.cmd)
            suk_pkg::CMD_INSERT: begin
               if (!found && !full) begin
                  rsp_item_in.ok       = 1'b1;
                  rsp_item_in.position = suk_pkg::FIELD_W'(slot_pos);
                  count_in             = count_ff + CW'(1);
               end
            end
            suk_pkg::CMD_REMOVE: begin
               if (found) begin
                  rsp_item_in.ok       = 1'b1;
                  rsp_item_in.position = suk_pkg::FIELD_W'(slot_pos);
                  count_in             = count_ff - CW'(1);
               end
            end
            suk_pkg::CMD_SEARCH: begin
               if (found) begin
                  rsp_item_in.ok            = 1'b1;
                  rsp_item_in.position      = suk_pkg::FIELD_W'(slot_pos);
                  rsp_item_in.found_payload = hit_payload;
               end
            end
            default: begin
               rsp_item_in.ok = 1'b1;
               count_in       = '0;
            end
         endcase
         rsp_item_in.entry_count = suk_pkg::FIELD_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---- assertions ----
   `SUK_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
                   count_ff <= CW'(CAPACITY), "count over capacity")
   `SUK_ASSERT_NOW(a_unique_hit, clock, reset, state_ff == ST_APPLY, $onehot0(eq_vec),
                   "duplicate keys held")
   `SUK_ASSERT_NOW(a_sorted_lt, clock, reset, state_ff == ST_APPLY,
                   ((lt_vec >> 1) & ~lt_vec) == '0, "compare flags not ordered")
   `SUK_ASSERT_NEXT(a_insert_count, clock, reset, insert_go,
                    count_ff == $past(count_ff) + CW'(1), "insert did not grow count")

endmodule
